// ===== design/iaid_pkg.sv =====
// Shared types, sizes and helper functions for the indexed array insert/delete core.
// Used by the cell, the read-back OR tree and the top level. No dependencies.
package iaid_pkg;

  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int FANIN   = 8;
  localparam int MAX_LVL = 16;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_EDIT   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_EDIT,
    CMD_DELETE,
    CMD_GET
  } cmd_t;

  typedef struct packed {
    logic              go;
    cmd_t              cmd;
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] wdata;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // Node count of tree level l (level 0 is the row of cells).
  function automatic int lvl_count(input int l);
    int n;
    n = DEPTH;
    for (int k = 0; k < MAX_LVL; k++) begin
      if (k < l) n = (n + FANIN - 1) / FANIN;
    end
    return n;
  endfunction

  // Number of registered levels needed to reduce the row to one node.
  function automatic int tree_levels();
    int n;
    int l;
    n = DEPTH;
    l = 0;
    for (int k = 0; k < MAX_LVL; k++) begin
      if (n > 1) begin
        n = (n + FANIN - 1) / FANIN;
        l = l + 1;
      end
    end
    return l;
  endfunction

  // Offset of level l (l >= 1) inside the flat node array.
  function automatic int node_base(input int l);
    int s;
    s = 0;
    for (int k = 1; k < MAX_LVL; k++) begin
      if (k < l) s = s + lvl_count(k);
    end
    return s;
  endfunction

  localparam int TREE_LVL = tree_levels();
  localparam int NODES    = node_base(TREE_LVL + 1);
  localparam int WALK_W   = $clog2(TREE_LVL + 1);

endpackage

// ===== design/iaid_cell.sv =====
// One list entry of the cell chain: holds a word and shifts with its neighbors.
// Depends on iaid_pkg for the control struct and command codes.
module iaid_cell import iaid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [WORD_W-1:0] below_data,
  input  logic [WORD_W-1:0] above_data,
  output logic [WORD_W-1:0] data,
  output logic [WORD_W-1:0] rd_word
);

  logic rd_sel;

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.cmd)
        CMD_INSERT: begin
          if (idx > ctl.pos) data <= below_data;
          else if (idx == ctl.pos) data <= ctl.wdata;
        end
        CMD_EDIT: begin
          if (idx == ctl.pos) data <= ctl.wdata;
        end
        CMD_DELETE: begin
          if (idx >= ctl.pos) data <= above_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sel <= 1'b0;
    end else if (ctl.go) begin
      rd_sel <= (ctl.cmd == CMD_GET) && (idx == ctl.pos);
    end
  end

  assign rd_word = data & {WORD_W{rd_sel}};

endmodule

// ===== design/iaid_or_tree.sv =====
// Registered OR tree that folds the masked cell words down to one read word.
// Depends on iaid_pkg for depth, fan-in and level layout.
module iaid_or_tree import iaid_pkg::*; (
  input  logic              clk,
  input  logic [WORD_W-1:0] leaf [DEPTH],
  output logic [WORD_W-1:0] root
);

  logic [WORD_W-1:0] node [NODES];

  for (genvar l = 1; l <= TREE_LVL; l++) begin : g_lvl
    localparam int PREV  = lvl_count(l - 1);
    localparam int CNT   = lvl_count(l);
    localparam int BASE  = node_base(l);
    localparam int PBASE = node_base(l - 1);
    for (genvar j = 0; j < CNT; j++) begin : g_node
      logic [WORD_W-1:0] acc;
      if (l == 1) begin : g_src
        always_comb begin
          acc = '0;
          for (int k = 0; k < FANIN; k++) begin
            if (j * FANIN + k < PREV) acc = acc | leaf[IDX_W'(j * FANIN + k)];
          end
        end
      end else begin : g_src
        always_comb begin
          acc = '0;
          for (int k = 0; k < FANIN; k++) begin
            if (j * FANIN + k < PREV) acc = acc | node[PBASE + j * FANIN + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        node[BASE + j] <= acc;
      end
    end
  end

  assign root = node[node_base(TREE_LVL)];

endmodule

// ===== design/indexed_array_insert_delete_core.sv =====
// Top level of the indexed array insert/delete core: decode, count, cell chain, read tree.
// Depends on iaid_pkg, iaid_cell and iaid_or_tree.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | func, position, write_data
//  out     | output    | out_valid/out_stall| status, read_data, fill_level, is_full, is_empty
//
// One request at a time: the cell chain shifts or writes the affected entries at the accept edge,
// then the result passes through the registered levels of the OR tree and is loaded into
// read_data, where it is presented with out_valid.
// Synchronous reset empties the list; entries themselves are not cleared.
// in_stall stays high during reset and until the result has been taken; a stalled
// result holds.
module indexed_array_insert_delete_core import iaid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [WORD_W-1:0] read_data,
  output logic [POS_W-1:0]  fill_level,
  output logic              is_full,
  output logic              is_empty
);

  state_t            state, state_next;
  logic [WALK_W-1:0] walk_cnt, walk_cnt_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic              get_ok, get_ok_next;
  logic [STAT_W-1:0] stat_next;
  logic              accept;
  cmd_t              cmd;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              full_now;
  cell_ctl_t         ctl;
  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] rd_word   [DEPTH];
  logic [WORD_W-1:0] root;

  assign accept   = in_valid && !in_stall;
  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(fill_count);
  assign full_now = (fill_count == CNT_W'(DEPTH));

  // Decode the request against the current count.
  always_comb begin
    cmd             = CMD_NONE;
    stat_next       = ST_OK;
    get_ok_next     = 1'b0;
    fill_count_next = fill_count;
    unique case (func)
      FUNC_APPEND: begin
        if (full_now) begin
          stat_next = ST_FULL;
        end else begin
          cmd             = CMD_INSERT;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      FUNC_INSERT: begin
        if (pos_ext > cnt_ext) begin
          stat_next = ST_BADIDX;
        end else if (full_now) begin
          stat_next = ST_FULL;
        end else begin
          cmd             = CMD_INSERT;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      FUNC_GET: begin
        if (pos_ext >= cnt_ext) begin
          stat_next = ST_BADIDX;
        end else begin
          cmd         = CMD_GET;
          get_ok_next = 1'b1;
        end
      end
      FUNC_EDIT: begin
        if (pos_ext >= cnt_ext) stat_next = ST_BADIDX;
        else                    cmd       = CMD_EDIT;
      end
      FUNC_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          stat_next = ST_BADIDX;
        end else begin
          cmd             = CMD_DELETE;
          fill_count_next = fill_count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Append is an insert at the end of the list.
  always_comb begin
    ctl.go    = accept && (cmd != CMD_NONE);
    ctl.cmd   = cmd;
    ctl.pos   = (func == FUNC_APPEND) ? IDX_W'(fill_count) : IDX_W'(position);
    ctl.wdata = write_data;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] below, above;
    if (i == 0) begin : g_lo
      assign below = '0;
    end else begin : g_lo
      assign below = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above = cell_data[i];
    end else begin : g_hi
      assign above = cell_data[i+1];
    end
    iaid_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .below_data (below),
      .above_data (above),
      .data       (cell_data[i]),
      .rd_word    (rd_word[i])
    );
  end

  iaid_or_tree u_tree (
    .clk  (clk),
    .leaf (rd_word),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_cnt   <= '0;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      walk_cnt   <= walk_cnt_next;
      if (accept) fill_count <= fill_count_next;
    end
  end

  always_comb begin
    state_next    = state;
    walk_cnt_next = walk_cnt;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    unique case (state)
      S_IDLE: begin
        // hold off requests while reset is asserted
        in_stall = rst;
        if (in_valid) begin
          state_next    = S_WALK;
          walk_cnt_next = '0;
        end
      end
      S_WALK: begin
        if (walk_cnt == WALK_W'(TREE_LVL)) state_next = S_DONE;
        else walk_cnt_next = walk_cnt + WALK_W'(1);
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result payload: counts at accept, read word once the tree has settled.
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= stat_next;
      get_ok     <= get_ok_next;
      fill_level <= POS_W'(fill_count_next);
      is_full    <= (fill_count_next == CNT_W'(DEPTH));
      is_empty   <= (fill_count_next == '0);
    end
    if (state == S_WALK && walk_cnt == WALK_W'(TREE_LVL)) begin
      read_data <= get_ok ? root : '1;
    end
  end

endmodule
